[sv/ecsc_pkg.sv]
package ecsc_pkg;

  // Fixed-point constants
  localparam logic [24:0] ONE_Q24    = 25'd16777216;
  localparam logic [28:0] ONE_Q28    = 29'd268435456;
  localparam logic [29:0] QTR_PI     = 30'd843314857;
  localparam logic [28:0] K273       = 29'd293131518;
  localparam logic [30:0] HALF_PI    = 31'd1686629713;
  localparam logic [30:0] NORM_FLOOR = 31'd1074;
  localparam logic [14:0] OUT_MAX    = 15'd16384;

  // Register reset values
  localparam logic        RST_ENABLE  = 1'b1;
  localparam logic [24:0] RST_ATTACK  = 25'd172950;
  localparam logic [24:0] RST_RELEASE = 25'd6988;
  localparam logic [14:0] RST_BASE    = 15'd16712;
  localparam logic [12:0] RST_SKEW    = 13'd328;
  localparam logic [14:0] RST_DEPTH   = 15'd2949;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_RELEASE = 3'd2,
    REG_BASE    = 3'd3,
    REG_SKEW    = 3'd4,
    REG_DEPTH   = 3'd5
  } reg_idx_t;

  // Iterative divider
  localparam int DVD_W = 57;
  localparam int DVS_W = 32;
  localparam int QUO_W = 29;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] INV_ITERS = 5'd29;
  localparam logic [CNT_W-1:0] OUT_ITERS = 5'd15;

  typedef struct packed {
    logic             start;
    logic             out_mode;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             ovf;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

[sv/ecsc_div.sv]
module ecsc_div import ecsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [QUO_W-1:0] quot;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ovf;

  logic [DVD_W-1:0] head;
  logic [5:0]       bit_idx;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    head    = req.out_mode ? (req.dividend >> OUT_ITERS) : (req.dividend >> INV_ITERS);
    bit_idx = 6'(cnt - 5'd1);
    trial   = {rem, dvd[bit_idx]};
    diff    = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.out_mode ? OUT_ITERS : INV_ITERS;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle; ovf flags a leading part that does not sit below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= DVS_W'(head);
      dvd  <= req.dividend;
      dvs  <= req.divisor;
      ovf  <= head >= DVD_W'(req.divisor);
      quot <= '0;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rem  <= diff[DVS_W-1:0];
        quot <= {quot[QUO_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DVS_W-1:0];
        quot <= {quot[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;

endmodule

[sv/envelope_driven_soft_clipper_unit.sv]
// With clipping off, an accepted input word goes through the envelope and drive steps to the
// output word; with clipping on, up to four arctangent passes on the shared 32x32 multiplier
// (with a reciprocal division for each argument above one) and two output divisions follow.
// Output stalls delay the result word.
// No new word is accepted while one is in flight.
// Reset (rst, synchronous): envelope cleared, registers to defaults, channels empty.
module envelope_driven_soft_clipper_unit import ecsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] first_sample,
  input  logic signed [15:0] second_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] first_out,
  output logic signed [15:0] second_out,
  output logic [24:0]        envelope_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'd1,
    S_ENV_DIFF = 18'd2,
    S_ENV_MUL  = 18'd4,
    S_ENV_UPD  = 18'd8,
    S_DRV_MUL  = 18'd16,
    S_DRV_SET  = 18'd32,
    S_CLIP_SET = 18'd64,
    S_NORM_ARG = 18'd128,
    S_NUM_MUL  = 18'd256,
    S_NUM_ARG  = 18'd512,
    S_FAT_CHK  = 18'd1024,
    S_FAT_DIV  = 18'd2048,
    S_POLY_W   = 18'd4096,
    S_POLY_P   = 18'd8192,
    S_POLY_M   = 18'd16384,
    S_POLY_R   = 18'd32768,
    S_OUT_DIV  = 18'd65536,
    S_FIN      = 18'd131072
  } state_t;

  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = {v[15], v};
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [15:0] v);
    logic signed [15:0] lim;
    lim = $signed({1'b0, OUT_MAX});
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  state_t state;

  // Configuration
  logic        enable;
  logic [24:0] attack_coeff;
  logic [24:0] release_coeff;
  logic [14:0] base_drive;
  logic [12:0] drive_skew;
  logic [14:0] env_depth;

  // Datapath
  logic signed [15:0] smp0, smp1;
  logic [24:0] target, envelope, diff, coeff;
  logic        env_up;
  logic [63:0] prod;
  logic [16:0] drive;
  logic        k;
  logic [16:0] xmag, dmag;
  logic        xneg, dneg, dpos;
  logic [31:0] fa;
  logic        fsel, inv_mode;
  logic [28:0] pa;
  logic [30:0] pp;
  logic [30:0] norm;
  logic signed [15:0] res0, res1;

  logic [31:0] mul_x, mul_y;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Combinational helpers
  logic [17:0]        sum_mag;
  logic [26:0]        target_raw;
  logic [24:0]        env_c, coeff_raw, step;
  logic [15:0]        depth_term;
  logic signed [15:0] xsel;
  logic signed [18:0] sd;
  logic [30:0]        r, fres;
  logic [14:0]        q;
  logic               neg;
  logic signed [15:0] qval;
  logic               out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    sum_mag    = 18'(mag16(first_sample)) + 18'(mag16(second_sample));
    target_raw = {sum_mag, 9'd0};
    env_c      = (envelope > ONE_Q24) ? ONE_Q24 : envelope;
    coeff_raw  = (target > env_c) ? attack_coeff : release_coeff;
    step       = 25'((prod[48:0] + 49'd8388608) >> 24);
    depth_term = 16'((prod[39:0] + 40'd8388608) >> 24);
    xsel       = k ? smp1 : smp0;
    if (!xsel[15]) begin
      sd = $signed({2'b00, drive}) + $signed({6'd0, drive_skew});
    end else begin
      sd = $signed({2'b00, drive}) - $signed({6'd0, drive_skew});
    end
    r    = 31'((prod[60:0] + 61'd134217728) >> 28);
    fres = inv_mode ? (HALF_PI - r) : r;
    if (div_rsp.ovf || div_rsp.quot > QUO_W'(OUT_MAX)) begin
      q = OUT_MAX;
    end else begin
      q = div_rsp.quot[14:0];
    end
    neg  = (xneg != dneg) && (xmag != 17'd0) && (dmag != 17'd0);
    qval = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      S_ENV_MUL: begin
        mul_x = 32'(diff);
        mul_y = 32'(coeff);
      end
      S_DRV_MUL: begin
        mul_x = 32'(env_depth);
        mul_y = 32'(envelope);
      end
      S_NUM_MUL: begin
        mul_x = 32'(xmag);
        mul_y = 32'(dmag);
      end
      S_POLY_W: begin
        mul_x = 32'(K273);
        mul_y = 32'(ONE_Q28 - pa);
      end
      S_POLY_M: begin
        mul_x = 32'(pa);
        mul_y = 32'(pp);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // Divider requests: reciprocal for arctangent above one, then the final quotient
  always_comb begin
    div_req.start    = ((state == S_FAT_CHK) && (fa > 32'(ONE_Q28)))
                       || ((state == S_POLY_R) && fsel);
    div_req.out_mode = (state == S_POLY_R);
    if (div_req.out_mode) begin
      div_req.dividend = 57'({fres, 14'd0}) + 57'(norm >> 1);
      div_req.divisor  = 32'(norm);
    end else begin
      div_req.dividend = (57'd1 << 56) + 57'(fa >> 1);
      div_req.divisor  = fa;
    end
  end

  ecsc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= RST_ENABLE;
      attack_coeff  <= RST_ATTACK;
      release_coeff <= RST_RELEASE;
      base_drive    <= RST_BASE;
      drive_skew    <= RST_SKEW;
      env_depth     <= RST_DEPTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:  enable        <= cfg_data[0];
        REG_ATTACK:  attack_coeff  <= cfg_data;
        REG_RELEASE: release_coeff <= cfg_data;
        REG_BASE:    base_drive    <= cfg_data[14:0];
        REG_SKEW:    drive_skew    <= cfg_data[12:0];
        REG_DEPTH:   env_depth     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      envelope <= '0;
      k        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            state <= S_ENV_DIFF;
          end
        end
        S_ENV_DIFF: begin
          envelope <= env_c;
          state    <= S_ENV_MUL;
        end
        S_ENV_MUL: state <= S_ENV_UPD;
        S_ENV_UPD: begin
          envelope <= env_up ? (envelope + step) : (envelope - step);
          state    <= S_DRV_MUL;
        end
        S_DRV_MUL: state <= S_DRV_SET;
        S_DRV_SET: begin
          k     <= 1'b0;
          state <= enable ? S_CLIP_SET : S_FIN;
        end
        S_CLIP_SET: state <= S_NORM_ARG;
        S_NORM_ARG: state <= dpos ? S_FAT_CHK : S_NUM_MUL;
        S_NUM_MUL:  state <= S_NUM_ARG;
        S_NUM_ARG:  state <= S_FAT_CHK;
        S_FAT_CHK:  state <= (fa > 32'(ONE_Q28)) ? S_FAT_DIV : S_POLY_W;
        S_FAT_DIV: begin
          if (!div_rsp.busy) begin
            state <= S_POLY_W;
          end
        end
        S_POLY_W: state <= S_POLY_P;
        S_POLY_P: state <= S_POLY_M;
        S_POLY_M: state <= S_POLY_R;
        S_POLY_R: state <= fsel ? S_OUT_DIV : S_NUM_MUL;
        S_OUT_DIV: begin
          if (!div_rsp.busy) begin
            if (k) begin
              state <= S_FIN;
            end else begin
              k     <= 1'b1;
              state <= S_CLIP_SET;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        smp0   <= first_sample;
        smp1   <= second_sample;
        target <= (target_raw > 27'(ONE_Q24)) ? ONE_Q24 : target_raw[24:0];
      end
      S_ENV_DIFF: begin
        coeff  <= (coeff_raw > ONE_Q24) ? ONE_Q24 : coeff_raw;
        env_up <= target >= env_c;
        diff   <= (target >= env_c) ? (target - env_c) : (env_c - target);
      end
      S_DRV_SET: begin
        drive <= 17'(base_drive) + 17'(depth_term);
        res0  <= sat16(smp0);
        res1  <= sat16(smp1);
      end
      S_CLIP_SET: begin
        xmag <= mag16(xsel);
        xneg <= xsel[15];
        dneg <= sd[18];
        dmag <= sd[18] ? 17'(-sd) : sd[16:0];
        dpos <= !sd[18] && (sd != 19'sd0);
      end
      S_NORM_ARG: begin
        if (dpos) begin
          fa   <= 32'({dmag, 14'd0});
          fsel <= 1'b0;
        end else begin
          norm <= NORM_FLOOR;
        end
      end
      S_NUM_ARG: begin
        fa   <= prod[31:0];
        fsel <= 1'b1;
      end
      S_FAT_CHK: begin
        inv_mode <= fa > 32'(ONE_Q28);
        pa       <= fa[28:0];
      end
      S_FAT_DIV: begin
        pa <= (div_rsp.quot > ONE_Q28) ? ONE_Q28 : div_rsp.quot;
      end
      S_POLY_P: begin
        pp <= 31'(QTR_PI) + 31'((prod[57:0] + 58'd134217728) >> 28);
      end
      S_POLY_R: begin
        if (!fsel) begin
          norm <= (fres < NORM_FLOOR) ? NORM_FLOOR : fres;
        end
      end
      S_OUT_DIV: begin
        if (!div_rsp.busy) begin
          if (k) begin
            res1 <= qval;
          end else begin
            res0 <= qval;
          end
        end
      end
      default: ;
    endcase
  end

  // Output word register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      first_out      <= res0;
      second_out     <= res1;
      envelope_level <= envelope;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_ENV_DIFF))
    else $error("accepted word did not start the envelope step");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_env_range: assert property (@(posedge clk) disable iff (rst)
    envelope <= ONE_Q24)
    else $error("envelope above full scale");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (out_valid && state == S_IDLE))
    else $error("result word not parked");

endmodule

[tb/tb_envelope_driven_soft_clipper_unit.sv]
`timescale 1ns / 1ps

module tb_envelope_driven_soft_clipper_unit;
  import ecsc_pkg::*;

  localparam longint unsigned Q24      = 64'd16777216;
  localparam longint unsigned Q28      = 64'd268435456;
  localparam longint unsigned C_QPI    = 64'd843314857;
  localparam longint unsigned C_K273   = 64'd293131518;
  localparam longint unsigned C_HPI    = 64'd1686629713;
  localparam longint unsigned C_FLOOR  = 64'd1074;
  localparam int              SAT      = 16384;
  localparam logic [2:0]      IDX_SPARE_LO = 3'd6;
  localparam logic [2:0]      IDX_SPARE_HI = 3'd7;
  localparam int              SETTLE   = 300;
  localparam int              WD_LIMIT = 6000;
  localparam int              N_PHASES = 10;
  localparam int              PHASE_WORDS = 95;

  typedef enum logic [1:0] { ROW_WORD, ROW_KNOWN, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [24:0]       data;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] ea;
    logic signed [15:0] eb;
  } row_t;

  typedef struct {
    logic signed [15:0] first;
    logic signed [15:0] second;
    logic [24:0]        env;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] first_sample = '0;
  logic signed [15:0] second_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] first_out;
  logic signed [15:0] second_out;
  logic [24:0] envelope_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [24:0] cfg_data = '0;

  // shadow of the block's registers and envelope
  logic        m_enable;
  logic [24:0] m_attack, m_release, m_env;
  logic [14:0] m_base, m_depth;
  logic [12:0] m_skew;

  clip_res_t pending_results[$];
  row_t      stim_rows[$];
  int        n_errors = 0;
  int        idle_cycles = 0;
  bit        no_gaps = 1'b0;

  envelope_driven_soft_clipper_unit i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned atan_poly(input longint unsigned a);
    longint unsigned w, p;
    w = Q28 - a;
    p = C_QPI + ((C_K273 * w + (Q28 >> 1)) >> 28);
    return (a * p + (Q28 >> 1)) >> 28;
  endfunction

  function automatic longint unsigned atan_mag(input longint unsigned a);
    longint unsigned inv;
    if (a <= Q28) return atan_poly(a);
    inv = ((64'd1 << 56) + (a >> 1)) / a;
    if (inv > Q28) inv = Q28;
    return C_HPI - atan_poly(inv);
  endfunction

  function automatic logic signed [15:0] shape_sample(input int x, input longint drive);
    longint d;
    longint unsigned dmag, xmag, norm, num, q;
    bit neg;
    d = (x >= 0) ? drive + longint'(m_skew) : drive - longint'(m_skew);
    dmag = (d < 0) ? -d : d;
    xmag = longint'((x < 0) ? -x : x);
    norm = C_FLOOR;
    if (d > 0) begin
      norm = atan_mag(dmag << 14);
      if (norm < C_FLOOR) norm = C_FLOOR;
    end
    num = atan_mag(xmag * dmag);
    neg = ((x < 0) != (d < 0)) && xmag != 0 && dmag != 0;
    q = ((num << 14) + (norm >> 1)) / norm;
    if (q > SAT) q = longint'(SAT);
    return neg ? -16'(q) : 16'(q);
  endfunction

  function automatic logic signed [15:0] clamp_q14(input int v);
    if (v > SAT) return 16'(SAT);
    if (v < -SAT) return 16'(-SAT);
    return 16'(v);
  endfunction

  // advance the envelope and compute one result word
  function automatic clip_res_t clip_word(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    clip_res_t r;
    int ia, ib;
    longint unsigned tgt, env, coeff, stp;
    longint drive;
    ia = a;
    ib = b;
    tgt = longint'((ia < 0 ? -ia : ia) + (ib < 0 ? -ib : ib)) << 9;
    if (tgt > Q24) tgt = Q24;
    env = m_env;
    if (env > Q24) env = Q24;
    coeff = (tgt > env) ? m_attack : m_release;
    if (coeff > Q24) coeff = Q24;
    if (tgt >= env) begin
      stp = ((tgt - env) * coeff + (Q24 >> 1)) >> 24;
      env = env + stp;
    end else begin
      stp = ((env - tgt) * coeff + (Q24 >> 1)) >> 24;
      env = env - stp;
    end
    m_env = env[24:0];
    drive = longint'(m_base) + longint'((longint'(m_depth) * env + (Q24 >> 1)) >> 24);
    if (m_enable) begin
      r.first  = shape_sample(ia, drive);
      r.second = shape_sample(ib, drive);
    end else begin
      r.first  = clamp_q14(ia);
      r.second = clamp_q14(ib);
    end
    r.env = m_env;
    return r;
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return 16'($urandom);
    if (pick < 13) return '0;
    if (pick < 30) return 16'(int'($urandom_range(400)) - 200);
    if (pick < 36) return ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
    return 16'(int'($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [24:0] rand_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return Q24[24:0];
      2: return 25'h1FFFFFF;
      3: return 25'($urandom_range(200000));
      default: return 25'($urandom);
    endcase
  endfunction

  task automatic add_word(input logic signed [15:0] a, input logic signed [15:0] b);
    stim_rows.push_back('{ROW_WORD, '0, '0, a, b, '0, '0});
  endtask

  task automatic add_known(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic signed [15:0] ea, input logic signed [15:0] eb);
    stim_rows.push_back('{ROW_KNOWN, '0, '0, a, b, ea, eb});
  endtask

  task automatic add_cfg(input logic [2:0] idx, input logic [24:0] data);
    stim_rows.push_back('{ROW_CFG, idx, data, '0, '0, '0, '0});
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [24:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:  m_enable  = data[0];
      REG_ATTACK:  m_attack  = data;
      REG_RELEASE: m_release = data;
      REG_BASE:    m_base    = data[14:0];
      REG_SKEW:    m_skew    = data[12:0];
      REG_DEPTH:   m_depth   = data[14:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic signed [15:0] a, input logic signed [15:0] b,
                           input bit known, input logic signed [15:0] ea,
                           input logic signed [15:0] eb);
    int gap;
    clip_res_t r;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(3, 1);
        default:       gap = $urandom_range(400, 20);
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    first_sample  <= a;
    second_sample <= b;
    do @(posedge clk); while (in_stall);
    r = clip_word(a, b);
    if (known) begin
      r.first  = ea;
      r.second = eb;
    end
    pending_results.push_back(r);
  endtask

  // receiver back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(5);
        end
        6, 7, 8: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(4);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(300, 30);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    clip_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word: %0d %0d env %0d",
                                     first_out, second_out, envelope_level);
      end else begin
        e = pending_results.pop_front();
        if (e.first !== first_out || e.second !== second_out || e.env !== envelope_level) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp %0d %0d env %0d, got %0d %0d env %0d",
                     e.first, e.second, e.env, first_out, second_out, envelope_level);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    m_enable  = RST_ENABLE;
    m_attack  = RST_ATTACK;
    m_release = RST_RELEASE;
    m_base    = RST_BASE;
    m_skew    = RST_SKEW;
    m_depth   = RST_DEPTH;
    m_env     = '0;

    // directed: defaults first, full scale maps onto itself
    add_known(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_known(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
    add_word(16'sd32767, -16'sd32768);
    add_word(16'sd1, -16'sd1);
    add_word(16'sd8192, 16'sd0);
    add_word(-16'sd100, 16'sd3000);
    add_cfg(REG_ENABLE, 25'd0);
    add_known(16'sd32767, -16'sd32768, 16'sd16384, -16'sd16384);
    add_known(16'sd123, -16'sd4567, 16'sd123, -16'sd4567);
    add_cfg(REG_ENABLE, 25'd1);
    // no drive at all, then negative drive for negative samples
    add_cfg(REG_BASE, 25'd0);
    add_cfg(REG_SKEW, 25'd0);
    add_cfg(REG_DEPTH, 25'd0);
    add_known(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_word(16'sd5000, -16'sd5000);
    add_cfg(REG_SKEW, 25'd4096);
    add_word(16'sd5000, -16'sd5000);
    add_word(-16'sd1, 16'sd1);
    // oversized coefficients and extreme drive
    add_cfg(REG_ATTACK, 25'h1FFFFFF);
    add_cfg(REG_RELEASE, 25'h1FFFFFF);
    add_cfg(REG_BASE, 25'd32767);
    add_cfg(REG_DEPTH, 25'd32767);
    add_cfg(REG_SKEW, 25'd8191);
    add_word(-16'sd32768, -16'sd32768);
    add_word(16'sd16384, 16'sd7);
    add_word(16'sd0, 16'sd0);
    add_cfg(IDX_SPARE_LO, 25'h1FFFFFF);
    add_cfg(IDX_SPARE_HI, 25'd0);
    add_word(16'sd200, -16'sd300);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        if (in_valid) in_valid <= 1'b0;
        drain();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_word(stim_rows[i].a, stim_rows[i].b, stim_rows[i].kind == ROW_KNOWN,
                  stim_rows[i].ea, stim_rows[i].eb);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      no_gaps = (p % 4 == 3);
      write_reg(REG_ENABLE, ($urandom_range(3) != 0) ? 25'd1 : 25'd0);
      case (p)
        0: begin
          write_reg(REG_ATTACK, RST_ATTACK);
          write_reg(REG_RELEASE, RST_RELEASE);
          write_reg(REG_BASE, 25'(RST_BASE));
          write_reg(REG_SKEW, 25'(RST_SKEW));
          write_reg(REG_DEPTH, 25'(RST_DEPTH));
        end
        1: begin
          write_reg(REG_ATTACK, Q24[24:0]);
          write_reg(REG_RELEASE, '0);
          write_reg(REG_BASE, 25'd32767);
          write_reg(REG_SKEW, 25'd4096);
          write_reg(REG_DEPTH, 25'd16384);
        end
        2: begin
          write_reg(REG_ATTACK, '0);
          write_reg(REG_RELEASE, Q24[24:0]);
          write_reg(REG_BASE, '0);
          write_reg(REG_SKEW, '0);
          write_reg(REG_DEPTH, '0);
        end
        default: begin
          write_reg(REG_ATTACK, rand_coeff());
          write_reg(REG_RELEASE, rand_coeff());
          write_reg(REG_BASE, ($urandom_range(4) == 0) ? 25'($urandom)
                                                       : 25'($urandom_range(32767)));
          write_reg(REG_SKEW, ($urandom_range(4) == 0) ? 25'($urandom)
                                                       : 25'($urandom_range(4096)));
          write_reg(REG_DEPTH, ($urandom_range(4) == 0) ? 25'($urandom)
                                                        : 25'($urandom_range(16384)));
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++)
        send_word(rand_sample(), rand_sample(), 1'b0, '0, '0);
    end

    in_valid <= 1'b0;
    no_gaps = 1'b0;
    drain();
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ecsc_pkg.sv
sv/ecsc_div.sv
sv/envelope_driven_soft_clipper_unit.sv
tb/tb_envelope_driven_soft_clipper_unit.sv
